@@ hdl/bba_pkg.sv @@
package bba_pkg;

   // Bitmap geometry.
   localparam int unsigned WORD_BITS          = 32;
   localparam int unsigned BIT_W              = $clog2(WORD_BITS);
   localparam int unsigned MAX_BLOCKS_DEFAULT = 32768;

   // The free counter is 16 bits wide, so its cap never exceeds this.
   localparam int unsigned COUNT_LIMIT = 65535;

   // Field widths.
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned WIDX_W   = 10;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned TOTAL_W  = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TOTAL_BLOCKS = 1'b0;
   localparam logic CSR_DATA_START   = 1'b1;

   // Outcome of searching one bitmap word for a free block.
   typedef struct packed {
      logic                 found;
      logic [BIT_W-1:0]     bit_idx;
      logic [WORD_BITS-1:0] new_word;
   } search_result_type;

endpackage

@@ hdl/bba_word_search.sv @@
module bba_word_search (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   input  logic [bba_pkg::WORD_BITS-1:0] valid_mask,
   output bba_pkg::search_result_type    result
);

   logic [bba_pkg::WORD_BITS-1:0] cand;
   logic [bba_pkg::WORD_BITS-1:0] lowest;
   logic [bba_pkg::BIT_W-1:0]     idx;

   // Isolate the lowest clear bit among the bits that may be granted.
   assign cand   = ~word & valid_mask;
   assign lowest = cand & (~cand + bba_pkg::WORD_BITS'(1));

   // Encode the one-hot bit into its position.
   always_comb begin
      idx = '0;
      for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
         if (lowest[b]) begin
            idx = idx | bba_pkg::BIT_W'(b);
         end
      end
   end

   assign result.found    = |cand;
   assign result.bit_idx  = idx;
   assign result.new_word = word | lowest;

endmodule

@@ hdl/block_bitmap_allocator_unit.sv @@
// Channel   Direction  Handshake                Contents
// req       in         req_tvalid/req_tready    tuser: kind; tdata: address, index, data
// rsp       out        rsp_tvalid/rsp_tready    tuser: status; tdata: grant, word, count
// csr       in         csr_we (no wait)         index selects total_blocks or data_start
//
// After reset a clearing pass zeroes the bitmap, one word a cycle, covering all
// MAX_BLOCKS / 32 words (1024 at the default); no request word is taken meanwhile.
// Free, load, read and set-count requests pass from the decode state to the result
// register, a mapped free by way of a read and a write state, a read by a wait state.
// An allocate walks the bitmap one word a cycle through the single read port of the
// bitmap memory and the one word search. Reset is synchronous. A result waiting
// on rsp_tready stalls the block only when the next result is ready to leave.
module block_bitmap_allocator_unit #(
   parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] block_address, [41:32] word_index, [73:42] word_data, [79:74] zero
   input  logic [79:0]                   req_tdata,
   // [2:0] kind
   input  logic [bba_pkg::KIND_W-1:0]    req_tuser,

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] allocated_address, [63:32] read_word, [79:64] free_count
   output logic [79:0]                   rsp_tdata,
   // [1:0] status
   output logic [bba_pkg::STATUS_W-1:0]  rsp_tuser,

   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int unsigned WB        = bba_pkg::WORD_BITS;
   localparam int unsigned BW        = bba_pkg::BIT_W;
   localparam int unsigned MAP_WORDS = MAX_BLOCKS / WB;
   localparam int unsigned MA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned SCAN_W    = $clog2(MAP_WORDS + 1);
   localparam int unsigned CAP       = (MAX_BLOCKS > bba_pkg::COUNT_LIMIT) ?
                                       bba_pkg::COUNT_LIMIT : MAX_BLOCKS;
   localparam int unsigned RAW_W     = bba_pkg::TOTAL_W + 1 - BW;

   localparam logic [bba_pkg::COUNT_W-1:0] CAP_VALUE = bba_pkg::COUNT_W'(CAP);

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_DECODE    = 4'd2;
   localparam logic [3:0] ST_SCAN      = 4'd3;
   localparam logic [3:0] ST_GRANT     = 4'd4;
   localparam logic [3:0] ST_FREE_RD   = 4'd5;
   localparam logic [3:0] ST_FREE_WR   = 4'd6;
   localparam logic [3:0] ST_READ_WAIT = 4'd7;
   localparam logic [3:0] ST_RESP      = 4'd8;

   // Bitmap memory: one write port, one registered read port.
   logic [WB-1:0]   map_mem [MAP_WORDS];
   logic            mem_we;
   logic [MA_W-1:0] mem_waddr;
   logic [WB-1:0]   mem_wdata;
   logic            mem_re;
   logic [MA_W-1:0] mem_raddr;
   logic [WB-1:0]   mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= map_mem[mem_raddr];
      end
   end

   // Control and payload registers.
   logic [3:0]                      state_ff, state_in;
   logic [MA_W-1:0]                 clr_ptr_ff, clr_ptr_in;
   logic [bba_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic [bba_pkg::ADDR_W-1:0]      data_start_ff, data_start_in;
   logic [bba_pkg::COUNT_W-1:0]     counter_ff, counter_in;

   logic [bba_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [bba_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [bba_pkg::WIDX_W-1:0]      widx_ff, widx_in;
   logic [bba_pkg::DATA_W-1:0]      wdata_ff, wdata_in;

   logic [SCAN_W-1:0]               scan_words_ff, scan_words_in;
   logic [SCAN_W-1:0]               issue_ptr_ff, issue_ptr_in;
   logic [SCAN_W-1:0]               chk_ptr_ff, chk_ptr_in;
   logic                            pend_ff, pend_in;
   logic [WB-1:0]                   mask_ff, mask_in;
   logic [bba_pkg::TOTAL_W-1:0]     idx_ff, idx_in;

   logic [bba_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [bba_pkg::ADDR_W-1:0]      res_grant_ff, res_grant_in;
   logic [bba_pkg::DATA_W-1:0]      res_word_ff, res_word_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]      rsp_grant_ff, rsp_grant_in;
   logic [bba_pkg::DATA_W-1:0]      rsp_word_ff, rsp_word_in;
   logic [bba_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // The scan and the free range check both use the smaller of the configured
   // total and the bitmap capacity.
   logic [bba_pkg::TOTAL_W-1:0]     eff_total;
   logic [bba_pkg::TOTAL_W:0]       words_sum;
   logic [RAW_W-1:0]                words_raw;
   logic [SCAN_W-1:0]               words_capped;
   logic [bba_pkg::TOTAL_W:0]       scan_rem;
   logic [bba_pkg::ADDR_W-1:0]      free_diff;
   logic                            free_bad;
   logic                            widx_in_map;
   logic                            req_fire;
   logic                            slot_free;

   bba_pkg::search_result_type      search;

   always_comb begin
      if (32'(total_ff) > MAX_BLOCKS) begin
         eff_total = bba_pkg::TOTAL_W'(MAX_BLOCKS);
      end else begin
         eff_total = total_ff;
      end
   end

   // Number of words that hold grantable bits, limited to the map size.
   assign words_sum = {1'b0, eff_total} + (bba_pkg::TOTAL_W + 1)'(WB - 1);
   assign words_raw = words_sum[bba_pkg::TOTAL_W:BW];

   always_comb begin
      if (32'(words_raw) > MAP_WORDS) begin
         words_capped = SCAN_W'(MAP_WORDS);
      end else begin
         words_capped = SCAN_W'(words_raw);
      end
   end

   // Grantable bits left from the start of the word being issued.
   assign scan_rem = {1'b0, eff_total} - (bba_pkg::TOTAL_W + 1)'({issue_ptr_ff, BW'(0)});

   assign free_diff   = addr_ff - data_start_ff;
   assign free_bad    = (addr_ff < data_start_ff) || (free_diff >= 32'(eff_total));
   assign widx_in_map = 32'(widx_ff) < MAP_WORDS;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   bba_word_search u_search (
      .word       (mem_rdata_ff),
      .valid_mask (mask_ff),
      .result     (search)
   );

   always_comb begin
      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      total_in      = total_ff;
      data_start_in = data_start_ff;
      counter_in    = counter_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      widx_in       = widx_ff;
      wdata_in      = wdata_ff;
      scan_words_in = scan_words_ff;
      issue_ptr_in  = issue_ptr_ff;
      chk_ptr_in    = chk_ptr_ff;
      pend_in       = pend_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      res_word_in   = res_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      // Configuration writes land in any state.
      if (csr_we) begin
         unique case (csr_index)
            bba_pkg::CSR_TOTAL_BLOCKS: total_in      = csr_wdata[bba_pkg::TOTAL_W-1:0];
            bba_pkg::CSR_DATA_START:   data_start_in = csr_wdata;
            default:                   total_in      = total_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + MA_W'(1);
            if (clr_ptr_ff == MA_W'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               addr_in  = req_tdata[31:0];
               widx_in  = req_tdata[41:32];
               wdata_in = req_tdata[73:42];
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_status_in = bba_pkg::STATUS_OK;
            res_grant_in  = '0;
            res_word_in   = '0;
            state_in      = ST_RESP;
            unique case (kind_ff)
               bba_pkg::KIND_ALLOC: begin
                  scan_words_in = words_capped;
                  issue_ptr_in  = '0;
                  pend_in       = 1'b0;
                  state_in      = ST_SCAN;
               end
               bba_pkg::KIND_FREE: begin
                  if (free_bad) begin
                     res_status_in = bba_pkg::STATUS_RANGE;
                  end else begin
                     idx_in = free_diff[bba_pkg::TOTAL_W-1:0];
                     if (32'(free_diff[bba_pkg::TOTAL_W-1:BW]) < MAP_WORDS) begin
                        state_in = ST_FREE_RD;
                     end else if (counter_ff < CAP_VALUE) begin
                        // Beyond the map: only the counter moves.
                        counter_in = counter_ff + bba_pkg::COUNT_W'(1);
                     end
                  end
               end
               bba_pkg::KIND_LOAD: begin
                  if (widx_in_map) begin
                     mem_we    = 1'b1;
                     mem_waddr = MA_W'(widx_ff);
                     mem_wdata = WB'(wdata_ff);
                  end
               end
               bba_pkg::KIND_READ: begin
                  if (widx_in_map) begin
                     mem_re    = 1'b1;
                     mem_raddr = MA_W'(widx_ff);
                     state_in  = ST_READ_WAIT;
                  end
               end
               bba_pkg::KIND_SET: begin
                  if (wdata_ff > 32'(CAP)) begin
                     counter_in = CAP_VALUE;
                  end else begin
                     counter_in = wdata_ff[bba_pkg::COUNT_W-1:0];
                  end
               end
               default: begin
                  // Unused kinds leave the state alone and report ok.
                  res_status_in = bba_pkg::STATUS_OK;
               end
            endcase
         end

         ST_SCAN: begin
            // Issue the next word read while the previous word is searched.
            if (issue_ptr_ff < scan_words_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = issue_ptr_ff[MA_W-1:0];
               issue_ptr_in = issue_ptr_ff + SCAN_W'(1);
               chk_ptr_in   = issue_ptr_ff;
               pend_in      = 1'b1;
               if (scan_rem >= (bba_pkg::TOTAL_W + 1)'(WB)) begin
                  mask_in = '1;
               end else begin
                  mask_in = (WB'(1) << scan_rem[BW-1:0]) - WB'(1);
               end
            end else begin
               pend_in = 1'b0;
            end

            if (scan_words_ff == '0) begin
               res_status_in = bba_pkg::STATUS_NOSPACE;
               state_in      = ST_RESP;
            end else if (pend_ff) begin
               if (search.found) begin
                  mem_we    = 1'b1;
                  mem_waddr = chk_ptr_ff[MA_W-1:0];
                  mem_wdata = search.new_word;
                  idx_in    = bba_pkg::TOTAL_W'({chk_ptr_ff, search.bit_idx});
                  if (counter_ff != '0) begin
                     counter_in = counter_ff - bba_pkg::COUNT_W'(1);
                  end
                  state_in = ST_GRANT;
               end else if (chk_ptr_ff == scan_words_ff - SCAN_W'(1)) begin
                  res_status_in = bba_pkg::STATUS_NOSPACE;
                  state_in      = ST_RESP;
               end
            end
         end

         ST_GRANT: begin
            res_grant_in = data_start_ff + bba_pkg::ADDR_W'(idx_ff);
            state_in     = ST_RESP;
         end

         ST_FREE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = MA_W'(idx_ff[bba_pkg::TOTAL_W-1:BW]);
            state_in  = ST_FREE_WR;
         end

         ST_FREE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = MA_W'(idx_ff[bba_pkg::TOTAL_W-1:BW]);
            mem_wdata = mem_rdata_ff & ~(WB'(1) << idx_ff[BW-1:0]);
            // A double free still counts, up to the cap.
            if (counter_ff < CAP_VALUE) begin
               counter_in = counter_ff + bba_pkg::COUNT_W'(1);
            end
            state_in = ST_RESP;
         end

         ST_READ_WAIT: begin
            res_word_in = bba_pkg::DATA_W'(mem_rdata_ff);
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = res_grant_ff;
               rsp_word_in   = res_word_ff;
               rsp_count_in  = counter_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ptr_ff    <= '0;
         total_ff      <= '0;
         data_start_ff <= '0;
         counter_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         total_ff      <= total_in;
         data_start_ff <= data_start_in;
         counter_ff    <= counter_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      widx_ff       <= widx_in;
      wdata_ff      <= wdata_in;
      scan_words_ff <= scan_words_in;
      issue_ptr_ff  <= issue_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      res_word_ff   <= res_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_word_ff, rsp_grant_ff};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus is driven on the falling clock edge and everything is sampled on the
// rising edge. A shadow copy of the bitmap, the free counter and both registers
// predicts each result word at the moment its request word is accepted.
module testbench;

   localparam int unsigned MAP_WORDS    = bba_pkg::MAX_BLOCKS_DEFAULT / bba_pkg::WORD_BITS;
   localparam int unsigned COUNT_CAP    =
      (bba_pkg::MAX_BLOCKS_DEFAULT > bba_pkg::COUNT_LIMIT) ? bba_pkg::COUNT_LIMIT
                                                           : bba_pkg::MAX_BLOCKS_DEFAULT;
   // A full scan of the map is the slowest request, so the final quiet period
   // covers one of those with margin.
   localparam int unsigned DRAIN_CYCLES = MAP_WORDS + 64;
   localparam int unsigned CYCLE_LIMIT  = 10_000_000;
   localparam int unsigned TRAFFIC_WORDS = 80;
   localparam int unsigned REPORT_LIMIT = 10;

   // Request kinds with no function, which must leave all state alone.
   localparam logic [bba_pkg::KIND_W-1:0]    KIND_SPARE_LO = bba_pkg::KIND_SET + 1'b1;
   localparam logic [bba_pkg::KIND_W-1:0]    KIND_SPARE_HI = '1;
   localparam logic [bba_pkg::WORD_BITS-1:0] FULL_WORD     = '1;

   typedef struct packed {
      logic [bba_pkg::KIND_W-1:0] kind;
      logic [bba_pkg::ADDR_W-1:0] block_address;
      logic [bba_pkg::WIDX_W-1:0] word_index;
      logic [bba_pkg::DATA_W-1:0] word_data;
   } bitmap_request_type;

   // Field order matches {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64]}.
   typedef struct packed {
      logic [bba_pkg::STATUS_W-1:0] status;
      logic [bba_pkg::ADDR_W-1:0]   allocated_address;
      logic [bba_pkg::DATA_W-1:0]   read_word;
      logic [bba_pkg::COUNT_W-1:0]  free_count;
   } bitmap_outcome_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // [31:0] block_address, [41:32] word_index, [73:42] word_data, [79:74] zero
   logic [79:0]  req_tdata;
   // [2:0] kind
   logic [bba_pkg::KIND_W-1:0] req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [31:0] allocated_address, [63:32] read_word, [79:64] free_count
   logic [79:0]  rsp_tdata;
   // [1:0] status
   logic [bba_pkg::STATUS_W-1:0] rsp_tuser;
   logic         csr_we;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   // Shadow state of the allocator.
   logic [bba_pkg::WORD_BITS-1:0] shadow_map [MAP_WORDS];
   logic [bba_pkg::COUNT_W-1:0]   shadow_free_count;
   logic [bba_pkg::TOTAL_W-1:0]   shadow_total;
   logic [bba_pkg::ADDR_W-1:0]    shadow_base;

   // Results predicted for accepted requests, oldest first.
   bitmap_outcome_type outcome_queue [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   block_bitmap_allocator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is bounded even if the block hangs. The limit allows for the
   // clearing pass after reset and for a full-map scan on every request.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // The receiver stalls at random with the current percentage.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Blocks past the 16-bit register that the map can actually hold are ignored.
   function automatic int unsigned usable_blocks();
      return (shadow_total > bba_pkg::MAX_BLOCKS_DEFAULT) ? bba_pkg::MAX_BLOCKS_DEFAULT
                                                          : shadow_total;
   endfunction

   // Applies one request to the shadow state and returns the result it must give.
   function automatic bitmap_outcome_type allocator_outcome(bitmap_request_type r);
      bitmap_outcome_type         o;
      int unsigned                usable;
      int unsigned                w;
      int unsigned                b;
      logic [bba_pkg::ADDR_W-1:0] offset;
      bit                         found;
      o      = '0;
      usable = usable_blocks();
      found  = 1'b0;
      unique case (r.kind)
         bba_pkg::KIND_ALLOC: begin
            // First fit from block 0; a full word is skipped as a whole.
            for (w = 0; w * bba_pkg::WORD_BITS < usable && !found; w++) begin
               if (shadow_map[w] != FULL_WORD) begin
                  for (b = 0; b < bba_pkg::WORD_BITS && !found; b++) begin
                     if (w * bba_pkg::WORD_BITS + b < usable && !shadow_map[w][b]) begin
                        shadow_map[w][b] = 1'b1;
                        if (shadow_free_count != 0) shadow_free_count--;
                        o.allocated_address =
                           shadow_base + bba_pkg::ADDR_W'(w * bba_pkg::WORD_BITS + b);
                        found = 1'b1;
                     end
                  end
               end
            end
            if (!found) o.status = bba_pkg::STATUS_NOSPACE;
         end
         bba_pkg::KIND_FREE: begin
            // An address that wrapped past 2^32 is below the base and so refused.
            offset = r.block_address - shadow_base;
            if (r.block_address < shadow_base || offset >= usable) begin
               o.status = bba_pkg::STATUS_RANGE;
            end else begin
               shadow_map[offset / bba_pkg::WORD_BITS][offset % bba_pkg::WORD_BITS] = 1'b0;
               // A double free still counts, up to the cap.
               if (shadow_free_count < COUNT_CAP) shadow_free_count++;
            end
         end
         bba_pkg::KIND_LOAD: begin
            if (r.word_index < MAP_WORDS) shadow_map[r.word_index] = r.word_data;
         end
         bba_pkg::KIND_READ: begin
            if (r.word_index < MAP_WORDS) o.read_word = shadow_map[r.word_index];
         end
         bba_pkg::KIND_SET: begin
            shadow_free_count = (r.word_data > COUNT_CAP) ?
                                bba_pkg::COUNT_W'(COUNT_CAP) :
                                r.word_data[bba_pkg::COUNT_W-1:0];
         end
         default: begin
         end
      endcase
      o.free_count = shadow_free_count;
      return o;
   endfunction

   // Every result word is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      bitmap_outcome_type want;
      bitmap_outcome_type got;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64]};
         if (outcome_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result word: status %0d grant %h word %h count %0d",
                        $realtime, got.status, got.allocated_address, got.read_word,
                        got.free_count);
         end else begin
            want = outcome_queue.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch: expected status %0d grant %h word %h count %0d",
                           $realtime, want.status, want.allocated_address,
                           want.read_word, want.free_count);
                  $display("%0t:                got status %0d grant %h word %h count %0d",
                           $realtime, got.status, got.allocated_address,
                           got.read_word, got.free_count);
               end
            end
         end
      end
   end

   function automatic bitmap_request_type make_request(
      logic [bba_pkg::KIND_W-1:0] kind,
      logic [bba_pkg::ADDR_W-1:0] block_address,
      logic [bba_pkg::WIDX_W-1:0] word_index,
      logic [bba_pkg::DATA_W-1:0] word_data);
      bitmap_request_type r;
      r.kind          = kind;
      r.block_address = block_address;
      r.word_index    = word_index;
      r.word_data     = word_data;
      return r;
   endfunction

   // Bitmap contents from empty through sparse and dense to full.
   function automatic logic [bba_pkg::WORD_BITS-1:0] bitmap_pattern();
      unique case ($urandom_range(4))
         0: return '0;
         1: return FULL_WORD;
         2: return $urandom & $urandom;
         3: return $urandom | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // Called on a falling edge and returns on the falling edge after the request
   // word was accepted, so a following word can go out with no gap.
   task automatic send_request(input bitmap_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {6'b0, r.word_data, r.word_index, r.block_address};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      outcome_queue.push_back(allocator_outcome(r));
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (outcome_queue.size() != 0) @(negedge clock);
   endtask

   // Registers are only written once every pending result has come back.
   task automatic configure(input logic [bba_pkg::TOTAL_W-1:0] total,
                            input logic [bba_pkg::ADDR_W-1:0] base);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_index <= bba_pkg::CSR_TOTAL_BLOCKS;
      csr_wdata <= 32'(total);
      @(negedge clock);
      csr_index <= bba_pkg::CSR_DATA_START;
      csr_wdata <= base;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_total = total;
      shadow_base  = base;
   endtask

   // Right after reset the map must read back clear and nothing can be
   // allocated or freed, since the block total is zero.
   task automatic test_reset_defaults();
      send_request(make_request(bba_pkg::KIND_READ, '1, '0, '1));
      send_request(make_request(bba_pkg::KIND_READ, '0, bba_pkg::WIDX_W'(MAP_WORDS - 1), '0));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_SET, '0, '0, 32'd1));
   endtask

   // Counter saturation at both ends, bits past the total, a base near the top
   // of the address space, refused frees on both sides, and a double free.
   task automatic test_boundaries();
      logic [bba_pkg::ADDR_W-1:0] base;
      base = 32'hFFFF_FFF0;
      configure(16'd40, base);
      send_request(make_request(bba_pkg::KIND_SET, '0, '0, '1));
      send_request(make_request(bba_pkg::KIND_SET, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_LOAD, '0, 10'd0, FULL_WORD));
      // Only bits 0 to 7 of word 1 are below the total; with those taken the
      // allocator has to report no space although the word is not full.
      send_request(make_request(bba_pkg::KIND_LOAD, '0, 10'd1, 32'h0000_00FF));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_LOAD, '0, 10'd1, 32'h0000_007F));
      // Block 39 lies past 2^32 and wraps; the counter is zero and stays there.
      send_request(make_request(bba_pkg::KIND_ALLOC, '1, '1, '1));
      send_request(make_request(bba_pkg::KIND_FREE, base - 1, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + 40, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + 39, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + 5, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + 5, '0, '0));
      send_request(make_request(bba_pkg::KIND_SET, '0, '0, 32'(COUNT_CAP)));
      send_request(make_request(bba_pkg::KIND_FREE, base + 6, '0, '0));
      send_request(make_request(bba_pkg::KIND_READ, '0, 10'd1, '0));
      send_request(make_request(bba_pkg::KIND_LOAD, '0, bba_pkg::WIDX_W'(MAP_WORDS - 1),
                                32'hA5A5_A5A5));
      send_request(make_request(bba_pkg::KIND_READ, '1, bba_pkg::WIDX_W'(MAP_WORDS - 1), '1));
      send_request(make_request(KIND_SPARE_LO, '1, '1, '1));
      send_request(make_request(KIND_SPARE_HI, '1, '1, '1));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, '1, '0, '0));
   endtask

   // The whole map is filled so that allocations walk every word, the only
   // clear bit being the very last block. The register total exceeds what the
   // map holds, so the map size is the limit.
   task automatic test_full_map_scan();
      logic [bba_pkg::ADDR_W-1:0] base;
      base = 32'h0001_0000;
      configure('1, base);
      for (int unsigned w = 0; w < MAP_WORDS; w++)
         send_request(make_request(bba_pkg::KIND_LOAD, $urandom, bba_pkg::WIDX_W'(w),
                                   (w == MAP_WORDS - 1) ? 32'h7FFF_FFFF : FULL_WORD));
      send_request(make_request(bba_pkg::KIND_SET, '0, '0, 32'd1));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + bba_pkg::MAX_BLOCKS_DEFAULT,
                                '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base + bba_pkg::MAX_BLOCKS_DEFAULT - 1,
                                '0, '0));
      send_request(make_request(bba_pkg::KIND_FREE, base, '0, '0));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_ALLOC, '0, '0, '0));
      send_request(make_request(bba_pkg::KIND_READ, '0, bba_pkg::WIDX_W'(MAP_WORDS - 1), '0));
   endtask

   // Mostly allocate and free inside the configured area, with loads, reads and
   // counter writes mixed in; a tenth of the words are arbitrary.
   function automatic bitmap_request_type random_request(int unsigned usable,
                                                         int unsigned words);
      bitmap_request_type r;
      int unsigned        pick;
      r    = make_request(bba_pkg::KIND_ALLOC, $urandom, bba_pkg::WIDX_W'($urandom), $urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.kind = bba_pkg::KIND_ALLOC;
      end else if (pick < 60) begin
         r.kind = bba_pkg::KIND_FREE;
         pick   = $urandom_range(9);
         if (pick < 7 && usable != 0)
            r.block_address = shadow_base + $urandom_range(usable - 1);
         else if (pick == 7)
            r.block_address = shadow_base + usable;
         else if (pick == 8)
            r.block_address = shadow_base - 1;
      end else if (pick < 70) begin
         r.kind      = bba_pkg::KIND_LOAD;
         r.word_data = bitmap_pattern();
         if ($urandom_range(3) != 0 && words != 0)
            r.word_index = bba_pkg::WIDX_W'($urandom_range(words - 1));
      end else if (pick < 80) begin
         r.kind = bba_pkg::KIND_READ;
         if ($urandom_range(3) != 0 && words != 0)
            r.word_index = bba_pkg::WIDX_W'($urandom_range(words - 1));
      end else if (pick < 90) begin
         r.kind = bba_pkg::KIND_SET;
         if ($urandom_range(1) != 0) r.word_data = $urandom_range(COUNT_CAP + 4);
      end else begin
         r.kind = bba_pkg::KIND_W'($urandom);
      end
      return r;
   endfunction

   // One setting of the registers: load the first bitmap words in use (all when
   // ten or fewer, else eight) and the free counter, as a mount would, then run
   // random traffic on it. Totals that make scans long get only a short run.
   task automatic run_segment(inout int unsigned sent);
      int unsigned                 pick;
      int unsigned                 usable;
      int unsigned                 words;
      int unsigned                 mounted;
      int unsigned                 ops;
      logic [bba_pkg::TOTAL_W-1:0] total;
      logic [bba_pkg::ADDR_W-1:0]  base;
      pick = $urandom_range(99);
      if (pick < 6)       total = '0;
      else if (pick < 12) total = '1;
      else if (pick < 16) total = bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS_DEFAULT);
      else if (pick < 20) total = bba_pkg::TOTAL_W'($urandom);
      else                total = bba_pkg::TOTAL_W'($urandom_range(1, 320));
      pick = $urandom_range(99);
      if (pick < 15)      base = '0;
      else if (pick < 30) base = 32'hFFFF_FFFF - $urandom_range(400);
      else                base = $urandom;
      configure(total, base);
      usable  = usable_blocks();
      words   = (usable + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
      mounted = (words > 10) ? 8 : words;
      ops     = (words > 10) ? 24 : $urandom_range(40, 120);
      for (int unsigned w = 0; w < mounted; w++)
         send_request(make_request(bba_pkg::KIND_LOAD, $urandom, bba_pkg::WIDX_W'(w),
                                   bitmap_pattern()));
      send_request(make_request(bba_pkg::KIND_SET, $urandom, bba_pkg::WIDX_W'($urandom),
                                $urandom_range(usable)));
      repeat (ops) send_request(random_request(usable, words));
      sent += mounted + 1 + ops;
   endtask

   task automatic run_traffic(input int unsigned sender_pct, input int unsigned receiver_pct);
      int unsigned sent;
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      sent = 0;
      while (sent < TRAFFIC_WORDS) run_segment(sent);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = bba_pkg::CSR_TOTAL_BLOCKS;
      csr_wdata  = '0;
      for (int unsigned w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;
      shadow_free_count = '0;
      shadow_total      = '0;
      shadow_base       = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // The block clears its map after reset and holds off requests until then;
      // the first request word simply waits for req_tready.
      send_idle_pct  = 17;
      recv_stall_pct = 64;
      test_reset_defaults();
      test_boundaries();
      test_full_map_scan();
      run_traffic(17, 64);
      run_traffic(64, 17);
      run_traffic(0, 0);

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/bba_pkg.sv
hdl/bba_word_search.sv
hdl/block_bitmap_allocator_unit.sv
dv/testbench.sv
